### src/gbai_pkg.sv
// shared types and constants for the gyro bias calibration and angle integrator
`default_nettype none

package gbai_pkg;

    // number of calibration samples averaged into one bias value
    localparam int CAL_SAMPLES = 100;

    // reciprocal for the divide by CAL_SAMPLES, exact for magnitudes below 2^31
    localparam int CAL_SHIFT = 31 + $clog2(CAL_SAMPLES);
    localparam logic [63:0] CAL_MAGIC_WIDE =
        ((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [31:0] CAL_MAGIC = CAL_MAGIC_WIDE[31:0];
    localparam logic [7:0] CAL_COUNT_END = 8'(CAL_SAMPLES);

    // angle limits
    localparam logic signed [47:0] ANGLE_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ANGLE_MIN = {1'b1, {47{1'b0}}};

    // deadzone after reset
    localparam logic [15:0] DEADZONE_RESET = 16'd1000;

    // request kinds
    localparam logic REQ_CAL  = 1'b0;
    localparam logic REQ_MEAS = 1'b1;

    // one input item
    typedef struct packed {
        logic               req_type;
        logic signed [23:0] rate_z;
        logic [15:0]        elapsed_ms;
        logic               read_ok;
    } gbai_item_t;

    // calibration status toward the integrator and output
    typedef struct packed {
        logic               cal_done;
        logic signed [23:0] bias_cur;
        logic signed [23:0] bias_next;
    } gbai_cal_stat_t;

    // integrator results for one item
    typedef struct packed {
        logic signed [47:0] angle_next;
        logic signed [24:0] corrected_rate;
        logic               angle_saturated;
    } gbai_integ_stat_t;

endpackage

`default_nettype wire

### src/gbai_cal.sv
// calibration sum, sample count and bias register
`default_nettype none

module gbai_cal
    import gbai_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire gbai_item_t     item,
    output gbai_cal_stat_t      stat
);

    logic signed [31:0] sum_reg;
    logic signed [31:0] sum_next;
    logic [7:0]         count_reg;
    logic [7:0]         count_next;
    logic signed [23:0] bias_reg;
    logic signed [23:0] bias_next;

    logic               cal_fire;
    logic signed [31:0] sum_new;
    logic [7:0]         count_new;
    logic               run_end;
    logic [31:0]        sum_neg;
    logic [30:0]        sum_mag;
    logic [63:0]        quot_prod;
    logic [63:0]        quot_shift;
    logic [24:0]        quot;
    logic [24:0]        quot_neg;
    logic signed [23:0] bias_new;

    // running sum and count for this sample
    always_comb
    begin
        cal_fire  = fire && (item.req_type == REQ_CAL);
        sum_new   = sum_reg + {{8{item.rate_z[23]}}, item.rate_z};
        count_new = count_reg + 8'd1;
        run_end   = cal_fire && (count_new >= CAL_COUNT_END);
    end

    // divide by sample count, truncated toward zero via magnitude
    always_comb
    begin
        sum_neg    = 32'd0 - sum_new;
        sum_mag    = sum_new[31] ? sum_neg[30:0] : sum_new[30:0];
        quot_prod  = 64'(sum_mag) * 64'(CAL_MAGIC);
        quot_shift = quot_prod >> CAL_SHIFT;
        quot       = quot_shift[24:0];
        quot_neg   = 25'd0 - quot;
        bias_new   = sum_new[31] ? quot_neg[23:0] : quot[23:0];
    end

    // next state
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        bias_next  = bias_reg;
        if (run_end)
        begin
            sum_next   = '0;
            count_next = '0;
            bias_next  = bias_new;
        end
        else if (cal_fire)
        begin
            sum_next   = sum_new;
            count_next = count_new;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            bias_reg  <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            bias_reg  <= bias_next;
        end
    end

    assign stat.cal_done  = run_end;
    assign stat.bias_cur  = bias_reg;
    assign stat.bias_next = bias_next;

endmodule

`default_nettype wire

### src/gbai_integ.sv
// bias correction, deadzone and saturating angle accumulator
`default_nettype none

module gbai_integ
    import gbai_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire gbai_item_t     item,
    input  wire gbai_cal_stat_t cal,
    input  wire logic [15:0]    deadzone,
    output gbai_integ_stat_t    stat
);

    logic signed [47:0] angle_reg;
    logic signed [47:0] angle_next;

    logic               use_item;
    logic signed [24:0] corr_raw;
    logic signed [25:0] corr_wide;
    logic signed [25:0] dz_wide;
    logic               in_band;
    logic signed [24:0] corr_sel;
    logic signed [16:0] ms_wide;
    logic signed [41:0] step_prod;
    logic signed [49:0] angle_sum;
    logic               overflow;
    logic signed [47:0] angle_clip;

    // corrected rate with deadzone
    always_comb
    begin
        use_item  = (item.req_type == REQ_MEAS) && item.read_ok;
        corr_raw  = {item.rate_z[23], item.rate_z} - {cal.bias_cur[23], cal.bias_cur};
        corr_wide = {corr_raw[24], corr_raw};
        dz_wide   = {10'd0, deadzone};
        in_band   = (corr_wide > -dz_wide) && (corr_wide < dz_wide);
        corr_sel  = (use_item && !in_band) ? corr_raw : 25'sd0;
    end

    // rate times step, added and clipped
    always_comb
    begin
        ms_wide    = {1'b0, item.elapsed_ms};
        step_prod  = corr_sel * ms_wide;
        angle_sum  = {{2{angle_reg[47]}}, angle_reg} + {{8{step_prod[41]}}, step_prod};
        overflow   = (angle_sum[49] != angle_sum[48]) || (angle_sum[48] != angle_sum[47]);
        angle_clip = overflow ? (angle_sum[49] ? ANGLE_MIN : ANGLE_MAX) : angle_sum[47:0];
    end

    // next angle
    always_comb
    begin
        angle_next = angle_reg;
        if (fire)
        begin
            if (cal.cal_done)
            begin
                angle_next = '0;
            end
            else if (use_item)
            begin
                angle_next = angle_clip;
            end
        end
    end

    // angle register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
        end
        else
        begin
            angle_reg <= angle_next;
        end
    end

    assign stat.angle_next      = angle_next;
    assign stat.corrected_rate  = corr_sel;
    assign stat.angle_saturated = use_item && overflow;

endmodule

`default_nettype wire

### src/gyro_bias_cal_angle_integrator_top.sv
// top level: input register, calibration and integrator, result register
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    tuser: req_type; tdata: rate_z, elapsed_ms, read_ok
// m_*       out  m_tvalid / m_tready    tuser: cal_done, angle_saturated;
//                                       tdata: angle_udeg, bias_mdps, corrected_rate
// cfg_*     in   cfg_we                 deadzone_mdps
//
// one item per cycle sustained while the result side is not stalled; an item waits in the
// input register, moves to the result register and leaves it on an m_tready handshake.
// the bias/angle update of each item is a combinational multiply-accumulate, so the
// next item sees the state of this one without a gap.
// reset clears the calibration state, angle, bias and valid flags; deadzone goes to 1000.
// an output stall holds the result; the input register takes one item, then s_tready drops.
`default_nettype none

module gyro_bias_cal_angle_integrator_top
    import gbai_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    // input items
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [47:0]    s_tdata,   // rate_z[23:0], elapsed_ms[39:24], read_ok[40]
    input  wire logic           s_tuser,   // req_type
    // result items
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [103:0]        m_tdata,   // angle_udeg[47:0], bias_mdps[71:48],
                                           // corrected_rate[96:72]
    output logic [1:0]          m_tuser,   // cal_done[0], angle_saturated[1]
    // configuration
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_wdata
);

    logic             in_valid_reg;
    logic             in_valid_next;
    gbai_item_t       item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [103:0]     out_data_reg;
    logic [1:0]       out_user_reg;
    logic [15:0]      deadzone_reg;

    logic             s_fire;
    logic             advance;
    gbai_item_t       item_in;
    gbai_cal_stat_t   cal_stat;
    gbai_integ_stat_t integ_stat;

    // handshake
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !in_valid_reg || advance;
        s_fire         = s_tvalid && s_tready;
        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // unpack input item
    always_comb
    begin
        item_in.req_type   = s_tuser;
        item_in.rate_z     = s_tdata[23:0];
        item_in.elapsed_ms = s_tdata[39:24];
        item_in.read_ok    = s_tdata[40];
    end

    // valid flags and deadzone register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            deadzone_reg  <= DEADZONE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                deadzone_reg <= cfg_wdata;
            end
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg <= item_in;
        end
    end

    gbai_cal u_cal (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .stat  (cal_stat)
    );

    gbai_integ u_integ (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .item     (item_reg),
        .cal      (cal_stat),
        .deadzone (deadzone_reg),
        .stat     (integ_stat)
    );

    // result payload register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {7'd0, integ_stat.corrected_rate, cal_stat.bias_next,
                             integ_stat.angle_next};
            out_user_reg <= {integ_stat.angle_saturated, cal_stat.cal_done};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // a finished calibration run leaves the angle at zero
    a_cal_clears_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[47:0] == 48'd0))
        else $error("angle not cleared on calibration done");

    // calibration items never integrate a rate
    a_cal_no_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[96:72] == 25'd0 && !m_tuser[1]))
        else $error("calibration item carries rate or saturation");

    // saturation only with a nonzero integrated rate
    a_sat_needs_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[96:72] != 25'd0))
        else $error("saturation flagged with zero rate");

    // an item moving to the output always finds the result register free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

### tb/tb_gyro_bias_cal_angle_integrator_top.sv
// self-checking testbench for the gyro bias calibration and angle integrator top level
module tb_gyro_bias_cal_angle_integrator_top;
    import gbai_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_ITEMS = 60;
    localparam int DRIVE_ITEMS = 134;

    // tracks bias, calibration progress and angle, and holds the results still owed
    class gyro_angle_tracker;
        typedef struct {
            logic signed [47:0] angle;
            logic signed [23:0] bias;
            logic signed [24:0] corr;
            logic               done;
            logic               sat;
        } angle_result_t;

        angle_result_t      owed_results[$];
        logic signed [47:0] angle;
        logic signed [23:0] bias;
        logic signed [31:0] rate_sum;
        logic [7:0]         sample_count;
        logic [15:0]        deadzone;
        int                 mismatches;

        function new();
            angle        = '0;
            bias         = '0;
            rate_sum     = '0;
            sample_count = '0;
            deadzone     = DEADZONE_RESET;
            mismatches   = 0;
        endfunction

        function void set_deadzone(logic [15:0] value);
            deadzone = value;
        endfunction

        // apply one accepted item and queue the result it must produce
        function void note_sample(logic req, logic signed [23:0] rate, logic [15:0] ms,
                                  logic ok);
            angle_result_t r;
            longint        corr;
            longint        dzl;
            longint        nxt;
            longint        lim_hi;
            longint        lim_lo;
            corr   = 0;
            r.done = 1'b0;
            r.sat  = 1'b0;
            if (req == REQ_CAL)
            begin
                // calibration sums regardless of read status
                rate_sum     = rate_sum + rate;
                sample_count = sample_count + 8'd1;
                if (sample_count >= CAL_COUNT_END)
                begin
                    bias         = rate_sum / CAL_SAMPLES;
                    angle        = '0;
                    rate_sum     = '0;
                    sample_count = '0;
                    r.done       = 1'b1;
                end
            end
            else if (ok)
            begin
                // bias removal, deadzone, then saturating integration
                dzl  = deadzone;
                corr = rate - bias;
                if (corr > -dzl && corr < dzl)
                    corr = 0;
                lim_hi = ANGLE_MAX;
                lim_lo = ANGLE_MIN;
                nxt    = angle + corr * longint'(ms);
                if (nxt > lim_hi)
                begin
                    nxt   = lim_hi;
                    r.sat = 1'b1;
                end
                else if (nxt < lim_lo)
                begin
                    nxt   = lim_lo;
                    r.sat = 1'b1;
                end
                angle = nxt[47:0];
            end
            r.angle = angle;
            r.bias  = bias;
            r.corr  = corr[24:0];
            owed_results.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        // compare one accepted result with the oldest owed one
        task check_result(logic [103:0] data, logic [1:0] flags);
            angle_result_t      w;
            logic signed [47:0] got_angle;
            logic signed [23:0] got_bias;
            logic signed [24:0] got_corr;
            got_angle = data[47:0];
            got_bias  = data[71:48];
            got_corr  = data[96:72];
            if (owed_results.size() == 0)
            begin
                report($sformatf("result with no item waiting, angle %0d", got_angle));
                return;
            end
            w = owed_results.pop_front();
            if (got_angle !== w.angle)
                report($sformatf("angle_udeg got %0d expected %0d", got_angle, w.angle));
            if (got_bias !== w.bias)
                report($sformatf("bias_mdps got %0d expected %0d", got_bias, w.bias));
            if (got_corr !== w.corr)
                report($sformatf("corrected_rate got %0d expected %0d", got_corr, w.corr));
            if (flags[0] !== w.done)
                report($sformatf("cal_done got %b expected %b", flags[0], w.done));
            if (flags[1] !== w.sat)
                report($sformatf("angle_saturated got %b expected %b", flags[1], w.sat));
        endtask
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [47:0]    s_tdata = '0;
    logic           s_tuser = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [103:0]   m_tdata;
    logic [1:0]     m_tuser;
    logic           cfg_we = 1'b0;
    logic [15:0]    cfg_wdata = '0;

    gyro_angle_tracker tracker;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    gyro_bias_cal_angle_integrator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tuser);
    end

    // watchdog on stalled traffic
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[gyro_bias_cal_angle_integrator_top] ERROR");
            $finish;
        end
    end

    function automatic logic signed [23:0] clamp_rate(longint v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        if (v < -64'sd8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

    // offer one item, with random idle cycles ahead of it
    task send_sample(logic req, logic signed [23:0] rate, logic [15:0] ms, logic ok);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, ok, ms, rate};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_sample(req, rate, ms, ok);
        items_sent++;
    endtask

    // stop sending and wait until every owed result has come
    task wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.owed_results.size() != 0);
    endtask

    task write_deadzone(logic [15:0] value);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_deadzone(value);
    endtask

    // finish the current calibration run with samples around a center
    task calibrate_run(longint center, int spread);
        int          n;
        longint      v;
        logic [31:0] rnd;
        n = CAL_SAMPLES - int'(tracker.sample_count);
        repeat (n)
        begin
            rnd = $urandom;
            v   = center + longint'($urandom_range(2 * spread)) - spread;
            send_sample(REQ_CAL, clamp_rate(v), rnd[15:0], rnd[16]);
        end
    endtask

    // measurement run, mostly near the deadzone edges around the current bias
    task measure_burst(int len);
        int                 pick;
        int                 dz;
        longint             v;
        logic signed [23:0] rate;
        logic [15:0]        ms;
        logic [31:0]        rnd;
        repeat (len)
        begin
            dz   = tracker.deadzone;
            pick = $urandom_range(99);
            rnd  = $urandom;
            if (pick < 55)
            begin
                v    = longint'(tracker.bias) + longint'($urandom_range(2 * dz + 6)) - dz - 3;
                rate = clamp_rate(v);
            end
            else if (pick < 85)
                rate = rnd[23:0];
            else
            begin
                case (rnd[1:0])
                    2'd0: rate = 24'sh7FFFFF;
                    2'd1: rate = 24'sh800000;
                    2'd2: rate = '0;
                    default: rate = tracker.bias;
                endcase
            end
            pick = $urandom_range(99);
            rnd  = $urandom;
            if (pick < 65)
                ms = 16'($urandom_range(50));
            else if (pick < 90)
                ms = rnd[15:0];
            else
                ms = rnd[16] ? 16'hFFFF : 16'h0000;
            send_sample(REQ_MEAS, rate, ms, ($urandom_range(99) < 90));
        end
    endtask

    // unconstrained items of either kind
    task noise_burst(int len);
        logic [31:0] ra;
        logic [31:0] rb;
        repeat (len)
        begin
            ra = $urandom;
            rb = $urandom;
            send_sample(ra[24], ra[23:0], rb[15:0], rb[16]);
        end
    endtask

    // extreme bias by calibration, then full-scale rate until the angle clips
    task drive_to_limit(logic upward);
        if (tracker.sample_count != 0)
            calibrate_run(0, 5000);
        calibrate_run(upward ? -64'sd8388608 : 64'sd8388607, 0);
        repeat (DRIVE_ITEMS)
            send_sample(REQ_MEAS, upward ? 24'sh7FFFFF : 24'sh800000, 16'hFFFF, 1'b1);
    endtask

    initial
    begin
        logic [15:0] dz_value;
        int          phase_start;
        bit          paused;
        int          pick;
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // deadzone at its reset value: band edges, full scale, failed read, zero step
        send_sample(REQ_MEAS, 24'sd999, 16'd1000, 1'b1);
        send_sample(REQ_MEAS, -24'sd999, 16'd1, 1'b1);
        send_sample(REQ_MEAS, 24'sd1000, 16'd1, 1'b1);
        send_sample(REQ_MEAS, -24'sd1000, 16'hFFFF, 1'b1);
        send_sample(REQ_MEAS, 24'sh7FFFFF, 16'hFFFF, 1'b1);
        send_sample(REQ_MEAS, 24'sh800000, 16'hFFFF, 1'b1);
        send_sample(REQ_MEAS, 24'sh7FFFFF, 16'hFFFF, 1'b0);
        send_sample(REQ_MEAS, 24'sd12345, 16'd0, 1'b1);
        // calibration samples count even with a failed read
        send_sample(REQ_CAL, 24'sh7FFFFF, 16'd0, 1'b0);
        send_sample(REQ_CAL, 24'sh800000, 16'd7, 1'b1);
        send_sample(REQ_CAL, -24'sd1, 16'd0, 1'b0);
        // zero deadzone passes every rate
        write_deadzone(16'd0);
        send_sample(REQ_MEAS, 24'sd1, 16'd1, 1'b1);
        send_sample(REQ_MEAS, -24'sd1, 16'hFFFF, 1'b1);
        send_sample(REQ_MEAS, 24'sd0, 16'hFFFF, 1'b1);
        // widest deadzone
        write_deadzone(16'hFFFF);
        send_sample(REQ_MEAS, 24'sd65534, 16'd10, 1'b1);
        send_sample(REQ_MEAS, -24'sd65535, 16'd10, 1'b1);
        send_sample(REQ_MEAS, 24'sh7FFFFF, 16'hFFFF, 1'b1);
        send_sample(REQ_CAL, 24'sd0, 16'hFFFF, 1'b1);

        // random phases over idle modes and deadzone settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            case (ph)
                0: dz_value = DEADZONE_RESET;
                1: dz_value = 16'd0;
                2: dz_value = 16'hFFFF;
                4: dz_value = 16'd1;
                5: dz_value = 16'($urandom_range(3000));
                6: dz_value = 16'h8000;
                default: dz_value = 16'($urandom);
            endcase
            write_deadzone(dz_value);
            phase_start = items_sent;
            paused      = 1'b0;
            if (ph == 2)
                drive_to_limit(1'b1);
            if (ph == 5)
                drive_to_limit(1'b0);
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                // hold the sender once per phase until everything is out
                if (!paused && items_sent - phase_start >= PHASE_ITEMS / 2)
                begin
                    wait_drain();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 15)
                    calibrate_run(longint'($urandom_range(2000000)) - 1000000,
                                  $urandom_range(20000));
                else if (pick < 70)
                    measure_burst($urandom_range(40, 5));
                else
                    noise_burst($urandom_range(10, 1));
            end
        end

        wait_drain();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.owed_results.size() == 0)
            $display("[gyro_bias_cal_angle_integrator_top] OK");
        else
            $display("[gyro_bias_cal_angle_integrator_top] ERROR");
        $finish;
    end

endmodule

### sim.f
src/gbai_pkg.sv
src/gbai_cal.sv
src/gbai_integ.sv
src/gyro_bias_cal_angle_integrator_top.sv
tb/tb_gyro_bias_cal_angle_integrator_top.sv
